>>> rtl/mme_pkg.sv
package mme_pkg;

   localparam int MAX_DIM = 16;
   localparam int ELEM_WIDTH = 16;

   localparam int ROW_WIDTH = 4;
   localparam int VALUE_WIDTH = 16;
   localparam int CMD_WIDTH = 2;
   localparam int CFG_WIDTH = 5;
   localparam int CFG_RESET = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int PRODUCT_WIDTH = 36;
   localparam int MUL_WIDTH = 2 * ELEM_WIDTH;

   localparam int IDX_WIDTH = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_WIDTH = $clog2(MAX_DIM + 1);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_QUERY   = 2'd2
   } cmd_code_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 wr_a;
      logic                 wr_b;
      logic                 start;
      logic                 issue;
      logic [IDX_WIDTH-1:0] k;
      logic                 load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                 range_err;
      logic                 pipe_busy;
      logic [CNT_WIDTH-1:0] nk;
   } dp_status_type;

   function automatic logic [CNT_WIDTH-1:0] eff_size(input logic [CFG_WIDTH-1:0] r);
      logic [CNT_WIDTH-1:0] res;
      if (32'(r) > MAX_DIM) begin
         res = CNT_WIDTH'(MAX_DIM);
      end else begin
         res = CNT_WIDTH'(r);
      end
      return res;
   endfunction

   function automatic logic signed [ELEM_WIDTH-1:0] to_elem(
      input logic signed [VALUE_WIDTH-1:0] v);
      logic signed [31:0] wide;
      wide = 32'(v);
      return wide[ELEM_WIDTH-1:0];
   endfunction

endpackage

>>> rtl/mme_datapath.sv
module mme_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  mme_pkg::ctrl_cmd_type                     cmd,
   output mme_pkg::dp_status_type                    sts,
   input  logic [mme_pkg::ROW_WIDTH-1:0]             req_row,
   input  logic [mme_pkg::ROW_WIDTH-1:0]             req_col,
   input  logic signed [mme_pkg::VALUE_WIDTH-1:0]    req_value,
   input  logic                                      csr_we,
   input  logic [mme_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [mme_pkg::CFG_WIDTH-1:0]             csr_data,
   output logic signed [mme_pkg::PRODUCT_WIDTH-1:0]  rsp_product,
   output logic                                      rsp_range_error
);

   logic signed [mme_pkg::ELEM_WIDTH-1:0] mem_a [mme_pkg::DEPTH];
   logic signed [mme_pkg::ELEM_WIDTH-1:0] mem_b [mme_pkg::DEPTH];

   logic [mme_pkg::CFG_WIDTH-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [mme_pkg::ROW_WIDTH-1:0] row_ff, col_ff;
   logic signed [mme_pkg::ELEM_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic rd_vld_ff, mul_vld_ff;
   logic signed [mme_pkg::MUL_WIDTH-1:0] mul_ff;
   logic signed [mme_pkg::PRODUCT_WIDTH-1:0] acc_ff, acc_in;
   logic signed [mme_pkg::PRODUCT_WIDTH-1:0] product_ff;
   logic range_error_ff;

   logic wr_in_store;
   logic [mme_pkg::ADDR_WIDTH-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic signed [mme_pkg::ELEM_WIDTH-1:0] wr_elem;
   logic [mme_pkg::CNT_WIDTH-1:0] nr, nc;

   assign wr_in_store = (32'(req_row) < mme_pkg::MAX_DIM) && (32'(req_col) < mme_pkg::MAX_DIM);
   assign wr_addr = mme_pkg::ADDR_WIDTH'(32'(req_row) * mme_pkg::MAX_DIM + 32'(req_col));
   assign wr_elem = mme_pkg::to_elem(req_value);
   assign rd_addr_a = mme_pkg::ADDR_WIDTH'(32'(row_ff) * mme_pkg::MAX_DIM + 32'(cmd.k));
   assign rd_addr_b = mme_pkg::ADDR_WIDTH'(32'(cmd.k) * mme_pkg::MAX_DIM + 32'(col_ff));

   assign nr = mme_pkg::eff_size(rows_a_ff);
   assign nc = mme_pkg::eff_size(cols_b_ff);

   always_comb begin
      sts.nk = mme_pkg::eff_size(inner_dim_ff);
      sts.range_err = (32'(row_ff) >= 32'(nr)) || (32'(col_ff) >= 32'(nc));
      sts.pipe_busy = rd_vld_ff || mul_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_a && wr_in_store) begin
         mem_a[wr_addr] <= wr_elem;
      end
      if (cmd.wr_b && wr_in_store) begin
         mem_b[wr_addr] <= wr_elem;
      end
      if (cmd.issue) begin
         rd_a_ff <= mem_a[rd_addr_a];
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mme_pkg::CFG_WIDTH'(mme_pkg::CFG_RESET);
         inner_dim_ff <= mme_pkg::CFG_WIDTH'(mme_pkg::CFG_RESET);
         cols_b_ff    <= mme_pkg::CFG_WIDTH'(mme_pkg::CFG_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            mme_pkg::REG_ROWS_A:    rows_a_ff    <= csr_data;
            mme_pkg::REG_INNER_DIM: inner_dim_ff <= csr_data;
            mme_pkg::REG_COLS_B:    cols_b_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + mme_pkg::PRODUCT_WIDTH'(mul_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      mul_ff <= rd_a_ff * rd_b_ff;
      acc_ff <= acc_in;
      if (cmd.load_rsp) begin
         product_ff     <= sts.range_err ? '0 : acc_ff;
         range_error_ff <= sts.range_err;
      end
   end

   assign rsp_product = product_ff;
   assign rsp_range_error = range_error_ff;

endmodule

>>> rtl/mme_ctrl.sv
module mme_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mme_pkg::CMD_WIDTH-1:0]      req_cmd,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mme_pkg::ctrl_cmd_type              cmd,
   input  mme_pkg::dp_status_type             sts
);

   mme_pkg::state_type state_ff, state_in;
   logic [mme_pkg::CNT_WIDTH-1:0] k_ff, k_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mme_pkg::ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.k        = k_ff[mme_pkg::IDX_WIDTH-1:0];
      unique case (state_ff)
         mme_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_cmd)
                  mme_pkg::CMD_WRITE_A: cmd.wr_a = 1'b1;
                  mme_pkg::CMD_WRITE_B: cmd.wr_b = 1'b1;
                  mme_pkg::CMD_QUERY: begin
                     cmd.start = 1'b1;
                     k_in      = '0;
                     state_in  = mme_pkg::ST_ISSUE;
                  end
                  default: ;
               endcase
            end
         end
         mme_pkg::ST_ISSUE: begin
            if (sts.range_err || (k_ff == sts.nk)) begin
               state_in = mme_pkg::ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               k_in      = mme_pkg::CNT_WIDTH'(k_ff + 1'b1);
            end
         end
         mme_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = mme_pkg::ST_FINISH;
            end
         end
         mme_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mme_pkg::ST_IDLE;
            end
         end
         default: state_in = mme_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/matrix_multiply_engine.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_cmd, req_row, req_col, req_value
// rsp      out        rsp_valid/rsp_stall   rsp_product, rsp_range_error
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// Element writes are taken whenever no query is in progress. A query steps through
// the inner dimension on the single multiply-accumulate unit, one term per cycle.
// A query outside the product size finishes without issuing any terms.
// Reset restores all three size registers to 16; matrix elements are not cleared.
// A finished result waits in the output register while writes keep flowing.
module matrix_multiply_engine (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [mme_pkg::CMD_WIDTH-1:0]             req_cmd,
   input  logic [mme_pkg::ROW_WIDTH-1:0]             req_row,
   input  logic [mme_pkg::ROW_WIDTH-1:0]             req_col,
   input  logic signed [mme_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [mme_pkg::PRODUCT_WIDTH-1:0]  rsp_product,
   output logic                                      rsp_range_error,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mme_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [mme_pkg::CFG_WIDTH-1:0]             csr_data
);

   mme_pkg::ctrl_cmd_type  cmd;
   mme_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   mme_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_value       (req_value),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_product     (rsp_product),
      .rsp_range_error (rsp_range_error)
   );

endmodule

>>> rtl/mme_checker.sv
module mme_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_stall,
   input logic [mme_pkg::CMD_WIDTH-1:0]             req_cmd,
   input logic [mme_pkg::ROW_WIDTH-1:0]             req_row,
   input logic [mme_pkg::ROW_WIDTH-1:0]             req_col,
   input logic signed [mme_pkg::VALUE_WIDTH-1:0]    req_value,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic signed [mme_pkg::PRODUCT_WIDTH-1:0]  rsp_product,
   input logic                                      rsp_range_error,
   input logic                                      csr_valid,
   input logic                                      csr_ready,
   input logic [mme_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input logic [mme_pkg::CFG_WIDTH-1:0]             csr_data
);

   logic unused_ok;
   assign unused_ok = ^{req_row, req_col, req_value, csr_valid, csr_ready, csr_index, csr_data};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_product == '0)
      else $error("range error with nonzero product");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == mme_pkg::CMD_QUERY) |=> req_stall)
      else $error("new transfer taken during query");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a query in progress");

endmodule

bind matrix_multiply_engine mme_checker u_checker (.*);
